// File: rtl/rv64cx_pkg.sv
`timescale 1ns / 1ps

package rv64cx_pkg;

   // Base opcodes
   localparam logic [6:0] OP_IMM   = 7'h13;
   localparam logic [6:0] OP_IMM32 = 7'h1B;
   localparam logic [6:0] OP_REG   = 7'h33;
   localparam logic [6:0] OP_REG32 = 7'h3B;
   localparam logic [6:0] OP_LUI   = 7'h37;
   localparam logic [6:0] OP_JALR  = 7'h67;
   localparam logic [6:0] OP_BR    = 7'h63;
   localparam logic [6:0] OP_JAL   = 7'h6F;
   localparam logic [6:0] OP_LDF   = 7'h07;
   localparam logic [6:0] OP_LD    = 7'h03;
   localparam logic [6:0] OP_STF   = 7'h27;
   localparam logic [6:0] OP_ST    = 7'h23;

   localparam logic [11:0] SRA_BIT   = 12'h400;
   localparam logic [31:0] WORD_NOP  = 32'h0000_0013;
   localparam logic [31:0] WORD_EBRK = 32'h0010_0073;

   // Base funct3 / funct7 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_W    = 3'd2;
   localparam logic [2:0] F3_D    = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_SUB  = 7'h20;

   // Fixed registers
   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd1;
   localparam logic [4:0] REG_SP   = 5'd2;

   typedef enum logic [1:0] {
      QUAD_0 = 2'b00,
      QUAD_1 = 2'b01,
      QUAD_2 = 2'b10,
      QUAD_3 = 2'b11
   } quadrant_type;

   // Compressed funct3, per quadrant
   localparam logic [2:0] C0_ADDI4SPN = 3'd0;
   localparam logic [2:0] C0_FLD      = 3'd1;
   localparam logic [2:0] C0_LW       = 3'd2;
   localparam logic [2:0] C0_LD       = 3'd3;
   localparam logic [2:0] C0_RSVD     = 3'd4;
   localparam logic [2:0] C0_FSD      = 3'd5;
   localparam logic [2:0] C0_SW       = 3'd6;
   localparam logic [2:0] C0_SD       = 3'd7;

   localparam logic [2:0] C1_ADDI     = 3'd0;
   localparam logic [2:0] C1_ADDIW    = 3'd1;
   localparam logic [2:0] C1_LI       = 3'd2;
   localparam logic [2:0] C1_LUI      = 3'd3;
   localparam logic [2:0] C1_ALU      = 3'd4;
   localparam logic [2:0] C1_J        = 3'd5;
   localparam logic [2:0] C1_BEQZ     = 3'd6;
   localparam logic [2:0] C1_BNEZ     = 3'd7;

   localparam logic [2:0] C2_SLLI     = 3'd0;
   localparam logic [2:0] C2_FLDSP    = 3'd1;
   localparam logic [2:0] C2_LWSP     = 3'd2;
   localparam logic [2:0] C2_LDSP     = 3'd3;
   localparam logic [2:0] C2_CR       = 3'd4;
   localparam logic [2:0] C2_FSDSP    = 3'd5;
   localparam logic [2:0] C2_SWSP     = 3'd6;
   localparam logic [2:0] C2_SDSP     = 3'd7;

   // C.ALU sub-op select (bits 11:10) and funct2 (bits 6:5)
   localparam logic [1:0] ALU_SRLI = 2'd0;
   localparam logic [1:0] ALU_SRAI = 2'd1;
   localparam logic [1:0] ALU_ANDI = 2'd2;
   localparam logic [1:0] ALU_REG  = 2'd3;
   localparam logic [1:0] F2_SUB   = 2'd0;
   localparam logic [1:0] F2_XOR   = 2'd1;
   localparam logic [1:0] F2_OR    = 2'd2;
   localparam logic [1:0] F2_AND   = 2'd3;

   typedef struct packed {
      logic        illegal;
      logic [31:0] word;
   } exp_result_type;

   function automatic logic [31:0] enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                         logic [4:0] rs1, logic [4:0] rs2, logic [6:0] f7);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [6:0] op, logic [2:0] f3, logic [4:0] rs1,
                                         logic [4:0] rs2, logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
   endfunction

   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [12:0] imm);
      return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OP_BR};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], REG_ZERO, OP_JAL};
   endfunction

endpackage

// File: rtl/rv64cx_decoder.sv
`timescale 1ns / 1ps

// Pure combinational expansion of one compressed halfword.
module rv64cx_decoder (
   input  logic [15:0]                 c,
   output rv64cx_pkg::exp_result_type  result
);

   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [4:0]  rs2;
   logic [4:0]  rdp;
   logic [4:0]  rs1p;
   logic [5:0]  imm6;
   logic [11:0] imm6_sx;
   logic [11:0] imm_d;
   logic [11:0] imm_w;
   logic [11:0] imm_4spn;
   logic [11:0] imm_16sp;
   logic [20:0] imm_j;
   logic [12:0] imm_b;
   logic [11:0] ld_d;
   logic [11:0] st_d;
   logic [11:0] imm_lwsp;
   logic [11:0] imm_swsp;
   logic [2:0]  alu_f3;
   logic [6:0]  alu_f7;
   logic        bad;
   logic [31:0] word;

   assign f3   = c[15:13];
   assign rd   = c[11:7];
   assign rs2  = c[6:2];
   assign rdp  = {2'b01, c[4:2]};
   assign rs1p = {2'b01, c[9:7]};
   assign imm6 = {c[12], c[6:2]};
   assign imm6_sx  = {{6{imm6[5]}}, imm6};
   assign imm_d    = {4'b0, c[6:5], c[12:10], 3'b0};
   assign imm_w    = {5'b0, c[5], c[12:10], c[6], 2'b0};
   assign imm_4spn = {2'b0, c[10:7], c[12:11], c[5], c[6], 2'b0};
   assign imm_16sp = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0};
   assign imm_j    = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
   assign imm_b    = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
   assign ld_d     = {3'b0, c[4:2], c[12], c[6:5], 3'b0};
   assign st_d     = {3'b0, c[9:7], c[12:10], 3'b0};
   assign imm_lwsp = {4'b0, c[3:2], c[12], c[6:4], 2'b0};
   assign imm_swsp = {4'b0, c[8:7], c[12:9], 2'b0};

   always_comb begin
      unique case (c[6:5])
         rv64cx_pkg::F2_SUB: alu_f3 = rv64cx_pkg::F3_ADD;
         rv64cx_pkg::F2_XOR: alu_f3 = rv64cx_pkg::F3_XOR;
         rv64cx_pkg::F2_OR:  alu_f3 = rv64cx_pkg::F3_OR;
         default:            alu_f3 = rv64cx_pkg::F3_AND;
      endcase
      alu_f7 = (c[6:5] == rv64cx_pkg::F2_SUB) ? rv64cx_pkg::F7_SUB : rv64cx_pkg::F7_ZERO;
   end

   always_comb begin
      bad  = 1'b0;
      word = rv64cx_pkg::WORD_NOP;
      unique case (rv64cx_pkg::quadrant_type'(c[1:0]))
         rv64cx_pkg::QUAD_0: begin
            unique case (f3)
               rv64cx_pkg::C0_ADDI4SPN: begin
                  bad  = (imm_4spn == 12'd0);
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rdp, rv64cx_pkg::F3_ADD,
                                           rv64cx_pkg::REG_SP, imm_4spn);
               end
               rv64cx_pkg::C0_FLD:
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_LDF, rdp, rv64cx_pkg::F3_D,
                                           rs1p, imm_d);
               rv64cx_pkg::C0_LW:
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_LD, rdp, rv64cx_pkg::F3_W,
                                           rs1p, imm_w);
               rv64cx_pkg::C0_LD:
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_LD, rdp, rv64cx_pkg::F3_D,
                                           rs1p, imm_d);
               rv64cx_pkg::C0_RSVD:
                  bad = 1'b1;
               rv64cx_pkg::C0_FSD:
                  word = rv64cx_pkg::enc_s(rv64cx_pkg::OP_STF, rv64cx_pkg::F3_D,
                                           rs1p, rdp, imm_d);
               rv64cx_pkg::C0_SW:
                  word = rv64cx_pkg::enc_s(rv64cx_pkg::OP_ST, rv64cx_pkg::F3_W,
                                           rs1p, rdp, imm_w);
               default:
                  word = rv64cx_pkg::enc_s(rv64cx_pkg::OP_ST, rv64cx_pkg::F3_D,
                                           rs1p, rdp, imm_d);
            endcase
         end
         rv64cx_pkg::QUAD_1: begin
            unique case (f3)
               rv64cx_pkg::C1_ADDI: begin
                  if (rd != rv64cx_pkg::REG_ZERO && imm6 != 6'd0) begin
                     word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rd, rv64cx_pkg::F3_ADD,
                                              rd, imm6_sx);
                  end
               end
               rv64cx_pkg::C1_ADDIW: begin
                  bad  = (rd == rv64cx_pkg::REG_ZERO);
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM32, rd, rv64cx_pkg::F3_ADD,
                                           rd, imm6_sx);
               end
               rv64cx_pkg::C1_LI: begin
                  if (rd != rv64cx_pkg::REG_ZERO) begin
                     word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rd, rv64cx_pkg::F3_ADD,
                                              rv64cx_pkg::REG_ZERO, imm6_sx);
                  end
               end
               rv64cx_pkg::C1_LUI: begin
                  if (rd == rv64cx_pkg::REG_SP) begin
                     // C.ADDI16SP
                     bad  = (imm_16sp == 12'd0);
                     word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rv64cx_pkg::REG_SP,
                                              rv64cx_pkg::F3_ADD, rv64cx_pkg::REG_SP,
                                              imm_16sp);
                  end else begin
                     bad = (imm6 == 6'd0);
                     if (rd != rv64cx_pkg::REG_ZERO) begin
                        word = {{14{imm6[5]}}, imm6, rd, rv64cx_pkg::OP_LUI};
                     end
                  end
               end
               rv64cx_pkg::C1_ALU: begin
                  unique case (c[11:10])
                     rv64cx_pkg::ALU_SRLI: begin
                        if (imm6 != 6'd0) begin
                           word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rs1p,
                                                    rv64cx_pkg::F3_SR, rs1p,
                                                    {6'b0, imm6});
                        end
                     end
                     rv64cx_pkg::ALU_SRAI: begin
                        if (imm6 != 6'd0) begin
                           word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rs1p,
                                                    rv64cx_pkg::F3_SR, rs1p,
                                                    rv64cx_pkg::SRA_BIT | {6'b0, imm6});
                        end
                     end
                     rv64cx_pkg::ALU_ANDI:
                        word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rs1p,
                                                 rv64cx_pkg::F3_AND, rs1p, imm6_sx);
                     default: begin
                        if (!c[12]) begin
                           word = rv64cx_pkg::enc_r(rv64cx_pkg::OP_REG, rs1p, alu_f3,
                                                    rs1p, rdp, alu_f7);
                        end else begin
                           // SUBW / ADDW; the other two funct2 codes are reserved
                           bad  = c[6];
                           word = rv64cx_pkg::enc_r(rv64cx_pkg::OP_REG32, rs1p,
                                                    rv64cx_pkg::F3_ADD, rs1p, rdp, alu_f7);
                        end
                     end
                  endcase
               end
               rv64cx_pkg::C1_J:
                  word = rv64cx_pkg::enc_j(imm_j);
               rv64cx_pkg::C1_BEQZ:
                  word = rv64cx_pkg::enc_b(rv64cx_pkg::F3_BEQ, rs1p, imm_b);
               default:
                  word = rv64cx_pkg::enc_b(rv64cx_pkg::F3_BNE, rs1p, imm_b);
            endcase
         end
         rv64cx_pkg::QUAD_2: begin
            unique case (f3)
               rv64cx_pkg::C2_SLLI: begin
                  if (rd != rv64cx_pkg::REG_ZERO && imm6 != 6'd0) begin
                     word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_IMM, rd, rv64cx_pkg::F3_SLL,
                                              rd, {6'b0, imm6});
                  end
               end
               rv64cx_pkg::C2_FLDSP:
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_LDF, rd, rv64cx_pkg::F3_D,
                                           rv64cx_pkg::REG_SP, ld_d);
               rv64cx_pkg::C2_LWSP: begin
                  bad  = (rd == rv64cx_pkg::REG_ZERO);
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_LD, rd, rv64cx_pkg::F3_W,
                                           rv64cx_pkg::REG_SP, imm_lwsp);
               end
               rv64cx_pkg::C2_LDSP: begin
                  bad  = (rd == rv64cx_pkg::REG_ZERO);
                  word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_LD, rd, rv64cx_pkg::F3_D,
                                           rv64cx_pkg::REG_SP, ld_d);
               end
               rv64cx_pkg::C2_CR: begin
                  if (rs2 == rv64cx_pkg::REG_ZERO) begin
                     if (!c[12]) begin
                        // C.JR
                        bad  = (rd == rv64cx_pkg::REG_ZERO);
                        word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_JALR, rv64cx_pkg::REG_ZERO,
                                                 rv64cx_pkg::F3_ADD, rd, 12'd0);
                     end else if (rd == rv64cx_pkg::REG_ZERO) begin
                        word = rv64cx_pkg::WORD_EBRK;
                     end else begin
                        word = rv64cx_pkg::enc_i(rv64cx_pkg::OP_JALR, rv64cx_pkg::REG_RA,
                                                 rv64cx_pkg::F3_ADD, rd, 12'd0);
                     end
                  end else if (rd != rv64cx_pkg::REG_ZERO) begin
                     // C.MV adds to x0, C.ADD to rd
                     word = rv64cx_pkg::enc_r(rv64cx_pkg::OP_REG, rd, rv64cx_pkg::F3_ADD,
                                              c[12] ? rd : rv64cx_pkg::REG_ZERO, rs2,
                                              rv64cx_pkg::F7_ZERO);
                  end
               end
               rv64cx_pkg::C2_FSDSP:
                  word = rv64cx_pkg::enc_s(rv64cx_pkg::OP_STF, rv64cx_pkg::F3_D,
                                           rv64cx_pkg::REG_SP, rs2, st_d);
               rv64cx_pkg::C2_SWSP:
                  word = rv64cx_pkg::enc_s(rv64cx_pkg::OP_ST, rv64cx_pkg::F3_W,
                                           rv64cx_pkg::REG_SP, rs2, imm_swsp);
               default:
                  word = rv64cx_pkg::enc_s(rv64cx_pkg::OP_ST, rv64cx_pkg::F3_D,
                                           rv64cx_pkg::REG_SP, rs2, st_d);
            endcase
         end
         default:
            bad = 1'b1;
      endcase
   end

   assign result.illegal = bad;
   assign result.word    = bad ? 32'd0 : word;

endmodule

// File: rtl/rv64c_instruction_expander_unit.sv
`timescale 1ns / 1ps

// RV64C instruction expander. Each request carries one 16-bit compressed
// halfword; each response gives the equivalent 32-bit RV64I/F/D instruction,
// or illegal = 1 with a zero word for reserved encodings and quadrant 3.
// HINT encodings come out as the canonical NOP and C.EBREAK as EBREAK.
// Two register stages: the request register holds the halfword, the
// expansion is combinational, and the response register holds the result.
// A request is held in the request register, and its expansion is loaded
// into the response register; one request can be taken every cycle while
// req_stall is low. req_stall is asserted only when both stages are full
// and rsp_stall is high, so a waiting response does not block a new request.
// No state survives between requests; reset only clears the valid bits.
module rv64c_instruction_expander_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_compressed_word,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_illegal,
   output logic [31:0] rsp_expanded_word
);

   // request stage
   logic        req_valid_ff;
   logic        req_valid_in;
   logic [15:0] req_word_ff;

   // response stage
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rv64cx_pkg::exp_result_type rsp_result_ff;

   rv64cx_pkg::exp_result_type exp_result;

   logic rsp_adv;   // response stage may load
   logic req_adv;   // request stage may load

   assign rsp_adv   = !rsp_valid_ff || !rsp_stall;
   assign req_adv   = !req_valid_ff || rsp_adv;
   assign req_stall = !req_adv;

   assign req_valid_in = req_adv ? req_valid : req_valid_ff;
   assign rsp_valid_in = rsp_adv ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_adv && req_valid) begin
         req_word_ff <= req_compressed_word;
      end
      if (rsp_adv && req_valid_ff) begin
         rsp_result_ff <= exp_result;
      end
   end

   rv64cx_decoder u_decoder (
      .c      (req_word_ff),
      .result (exp_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_illegal       = rsp_result_ff.illegal;
   assign rsp_expanded_word = rsp_result_ff.word;

endmodule

// File: rtl/rv64cx_checker.sv
`timescale 1ns / 1ps

module rv64cx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [15:0] req_compressed_word,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_illegal,
   input logic [31:0] rsp_expanded_word
);

   // illegal responses carry a zero word
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |-> rsp_expanded_word == 32'd0)
      else $error("illegal response with nonzero word");

   // back-pressure only when the response side is stalled with a result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while response side is free");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_illegal)
                                 && $stable(rsp_expanded_word))
      else $error("stalled response changed");

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_compressed_word))
      else $error("stalled request changed");

endmodule

bind rv64c_instruction_expander_unit rv64cx_checker u_rv64cx_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_compressed_word (req_compressed_word),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_illegal         (rsp_illegal),
   .rsp_expanded_word   (rsp_expanded_word)
);
